/* hw/rtl/cau_pkg.sv */
// shared types, constants and codes of the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

  localparam int unsigned FracBits    = 16;
  localparam int unsigned OpW         = 32;
  localparam int unsigned ProdW       = 2 * OpW;
  localparam int unsigned SumW        = ProdW + 1;
  localparam int unsigned AbsW        = ProdW;
  localparam int unsigned NumShW      = AbsW + FracBits;
  localparam int unsigned HiW         = NumShW - OpW;
  localparam int unsigned DivSteps    = OpW;
  localparam int unsigned FrontStages = 5;
  localparam int unsigned Stages      = FrontStages + DivSteps + 1;

  typedef enum logic [2:0] {
    ActAdd   = 3'd0,
    ActSub   = 3'd1,
    ActMul   = 3'd2,
    ActDiv   = 3'd3,
    ActScale = 3'd4
  } cau_action_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDivZero = 2'd1,
    StSat     = 2'd2
  } cau_status_e;

  // result of everything but divide, carried past the divider
  typedef struct packed {
    logic           is_div;
    logic [1:0]     st;
    logic [OpW-1:0] rr;
    logic [OpW-1:0] ri;
  } cau_side_t;

  // one restoring-division lane: remainder and merged dividend/quotient shifter
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [ProdW-1:0] rem;
    logic [OpW-1:0]   mq;
  } cau_lane_t;

  typedef struct packed {
    cau_side_t        side;
    logic             dz;
    logic [ProdW-1:0] den;
    cau_lane_t        re;
    cau_lane_t        im;
  } cau_dstage_t;

endpackage

`default_nettype wire

/* hw/rtl/complex_arith_unit_core.sv */
// top level of the complex arithmetic unit: front stages, divider chain, output stage
// depends on cau_pkg, cau_front, cau_div_step, cau_back
`default_nettype none

// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide and
// scale by a real. One item may enter every clock cycle unless the input is
// stalled. The pipeline has five front stages (operand register, 32x32
// products, wide sums, truncation/saturation with divider magnitudes,
// quotient range check), one stage per quotient bit of the restoring divider
// (32 stages), and the output register. Every stage holds its own valid bit
// and loads whenever it is empty or the stage after it moves, so bubbles are
// squeezed out and new items are taken while a result waits at the output.
// Divide returns (a * conj b) / |b|^2 truncated toward zero; a zero
// denominator gives zero and divide-by-zero status; any clipped component
// gives saturated status.

module complex_arith_unit_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     action_i,
  input  logic signed [cau_pkg::OpW-1:0] a_re_i,
  input  logic signed [cau_pkg::OpW-1:0] a_im_i,
  input  logic signed [cau_pkg::OpW-1:0] b_re_i,
  input  logic signed [cau_pkg::OpW-1:0] b_im_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [cau_pkg::OpW-1:0] res_re_o,
  output logic signed [cau_pkg::OpW-1:0] res_im_o,
  output logic [1:0]                     status_o
);

  localparam int unsigned NStg = cau_pkg::Stages;
  localparam int unsigned FStg = cau_pkg::FrontStages;

  // per-stage valid and load enable
  logic [NStg-1:0] vld, en;

  // last stage moves when empty or when the item is taken
  assign en[NStg-1] = !vld[NStg-1] || !out_stall_i;

  // every other stage loads when empty or when its successor moves
  for (genvar k = 0; k < NStg - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign in_stall_o = !en[0];

  // stage data between divider steps
  cau_pkg::cau_dstage_t dstg [cau_pkg::DivSteps+1];

  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .en_i       (en[FStg-1:0]),
    .vld_o      (vld[FStg-1:0]),
    .stage_o    (dstg[0])
  );

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < cau_pkg::DivSteps; s++) begin : g_div
    cau_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[FStg+s]),
      .vld_i   (vld[FStg+s-1]),
      .stage_i (dstg[s]),
      .vld_o   (vld[FStg+s]),
      .stage_o (dstg[s+1])
    );
  end

  logic [cau_pkg::OpW-1:0] rre, rim;

  cau_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en[NStg-1]),
    .vld_i    (vld[NStg-2]),
    .stage_i  (dstg[cau_pkg::DivSteps]),
    .vld_o    (vld[NStg-1]),
    .res_re_o (rre),
    .res_im_o (rim),
    .status_o (status_o)
  );

  assign out_valid_o = vld[NStg-1];
  assign res_re_o    = $signed(rre);
  assign res_im_o    = $signed(rim);

  // input only backs up when the whole pipe is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&vld)))
    else $error("input stalled while pipe has room");

  // divide by zero always returns a zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == cau_pkg::StDivZero) |-> (res_re_o == '0 && res_im_o == '0))
    else $error("divide by zero with nonzero result");

  // saturated status means at least one component sits at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == cau_pkg::StSat) |->
      (res_re_o == 32'sh7FFFFFFF || res_re_o == 32'sh80000000 ||
       res_im_o == 32'sh7FFFFFFF || res_im_o == 32'sh80000000))
    else $error("saturated status without a clipped component");

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_re_o) &&
                                      $stable(res_im_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

/* hw/rtl/cau_front.sv */
// front stages: operand register, products, sums, saturation and divider setup
// depends on cau_pkg
`default_nettype none

module cau_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic [2:0]                             action_i,
  input  logic signed [cau_pkg::OpW-1:0]         a_re_i,
  input  logic signed [cau_pkg::OpW-1:0]         a_im_i,
  input  logic signed [cau_pkg::OpW-1:0]         b_re_i,
  input  logic signed [cau_pkg::OpW-1:0]         b_im_i,
  input  logic [cau_pkg::FrontStages-1:0]        en_i,
  output logic [cau_pkg::FrontStages-1:0]        vld_o,
  output cau_pkg::cau_dstage_t                   stage_o
);

  logic [cau_pkg::FrontStages-1:0] vld_q, vld_d;

  always_comb begin
    vld_d = vld_q;
    if (en_i[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < int'(cau_pkg::FrontStages); k++) begin
      if (en_i[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign vld_o = vld_q;

  // stage 1: operands
  logic [2:0]                     act1_q;
  logic signed [cau_pkg::OpW-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      act1_q <= action_i;
      ar1_q  <= a_re_i;
      ai1_q  <= a_im_i;
      br1_q  <= b_re_i;
      bi1_q  <= b_im_i;
    end
  end

  // stage 2: products and short sums
  logic [2:0]                       act2_q;
  logic signed [cau_pkg::ProdW-1:0] prr2_q, pii2_q, pri2_q, pir2_q, pbr2_q, pbi2_q;
  logic signed [cau_pkg::OpW:0]     sre2_q, sim2_q;
  logic signed [cau_pkg::OpW:0]     sre_d, sim_d;

  always_comb begin
    if (act1_q == cau_pkg::ActSub) begin
      sre_d = (cau_pkg::OpW+1)'(ar1_q) - (cau_pkg::OpW+1)'(br1_q);
      sim_d = (cau_pkg::OpW+1)'(ai1_q) - (cau_pkg::OpW+1)'(bi1_q);
    end else begin
      sre_d = (cau_pkg::OpW+1)'(ar1_q) + (cau_pkg::OpW+1)'(br1_q);
      sim_d = (cau_pkg::OpW+1)'(ai1_q) + (cau_pkg::OpW+1)'(bi1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      act2_q <= act1_q;
      prr2_q <= ar1_q * br1_q;
      pii2_q <= ai1_q * bi1_q;
      pri2_q <= ar1_q * bi1_q;
      pir2_q <= ai1_q * br1_q;
      pbr2_q <= br1_q * br1_q;
      pbi2_q <= bi1_q * bi1_q;
      sre2_q <= sre_d;
      sim2_q <= sim_d;
    end
  end

  // stage 3: wide sums
  logic [2:0]                          act3_q;
  logic                                shift3_q;
  logic signed [cau_pkg::SumW-1:0]     wre3_q, wim3_q, nre3_q, nim3_q;
  logic [cau_pkg::ProdW-1:0]           den3_q;
  logic signed [cau_pkg::SumW-1:0]     wre_d, wim_d;
  logic                                shift_d;

  always_comb begin
    wre_d   = '0;
    wim_d   = '0;
    shift_d = 1'b0;
    case (act2_q)
      cau_pkg::ActAdd, cau_pkg::ActSub: begin
        wre_d = cau_pkg::SumW'(sre2_q);
        wim_d = cau_pkg::SumW'(sim2_q);
      end
      cau_pkg::ActMul: begin
        wre_d   = cau_pkg::SumW'(prr2_q) - cau_pkg::SumW'(pii2_q);
        wim_d   = cau_pkg::SumW'(pri2_q) + cau_pkg::SumW'(pir2_q);
        shift_d = 1'b1;
      end
      cau_pkg::ActScale: begin
        wre_d   = cau_pkg::SumW'(prr2_q);
        wim_d   = cau_pkg::SumW'(pir2_q);
        shift_d = 1'b1;
      end
      default: begin
        wre_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      act3_q   <= act2_q;
      shift3_q <= shift_d;
      wre3_q   <= wre_d;
      wim3_q   <= wim_d;
      nre3_q   <= cau_pkg::SumW'(prr2_q) + cau_pkg::SumW'(pii2_q);
      nim3_q   <= cau_pkg::SumW'(pir2_q) - cau_pkg::SumW'(pri2_q);
      den3_q   <= $unsigned(pbr2_q) + $unsigned(pbi2_q);
    end
  end

  // stage 4: truncate and saturate, divider magnitudes
  cau_pkg::cau_side_t               side4_q, side_d;
  logic                             dz4_q, nre_neg4_q, nim_neg4_q;
  logic [cau_pkg::ProdW-1:0]        den4_q;
  logic [cau_pkg::NumShW-1:0]       mre4_q, mim4_q;
  logic signed [cau_pkg::SumW-1:0]  vre, vim, are_s, aim_s;
  logic                             sat_re, sat_im;
  logic [cau_pkg::OpW-1:0]          cre, cim;

  always_comb begin
    vre = shift3_q ? (wre3_q >>> cau_pkg::FracBits) : wre3_q;
    vim = shift3_q ? (wim3_q >>> cau_pkg::FracBits) : wim3_q;
    sat_re = !((&vre[cau_pkg::SumW-1:cau_pkg::OpW-1]) || !(|vre[cau_pkg::SumW-1:cau_pkg::OpW-1]));
    sat_im = !((&vim[cau_pkg::SumW-1:cau_pkg::OpW-1]) || !(|vim[cau_pkg::SumW-1:cau_pkg::OpW-1]));
    cre = sat_re ? {vre[cau_pkg::SumW-1], {(cau_pkg::OpW-1){!vre[cau_pkg::SumW-1]}}}
                 : vre[cau_pkg::OpW-1:0];
    cim = sat_im ? {vim[cau_pkg::SumW-1], {(cau_pkg::OpW-1){!vim[cau_pkg::SumW-1]}}}
                 : vim[cau_pkg::OpW-1:0];
    side_d.is_div = (act3_q == cau_pkg::ActDiv);
    case (act3_q)
      cau_pkg::ActAdd, cau_pkg::ActSub, cau_pkg::ActMul, cau_pkg::ActScale: begin
        side_d.rr = cre;
        side_d.ri = cim;
        side_d.st = (sat_re || sat_im) ? cau_pkg::StSat : cau_pkg::StOk;
      end
      default: begin
        side_d.rr = '0;
        side_d.ri = '0;
        side_d.st = cau_pkg::StOk;
      end
    endcase
    are_s = nre3_q[cau_pkg::SumW-1] ? -nre3_q : nre3_q;
    aim_s = nim3_q[cau_pkg::SumW-1] ? -nim3_q : nim3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      side4_q    <= side_d;
      dz4_q      <= (den3_q == '0);
      den4_q     <= den3_q;
      nre_neg4_q <= nre3_q[cau_pkg::SumW-1];
      nim_neg4_q <= nim3_q[cau_pkg::SumW-1];
      mre4_q     <= cau_pkg::NumShW'(are_s[cau_pkg::AbsW-1:0]) << cau_pkg::FracBits;
      mim4_q     <= cau_pkg::NumShW'(aim_s[cau_pkg::AbsW-1:0]) << cau_pkg::FracBits;
    end
  end

  // stage 5: quotient range check and divider start
  cau_pkg::cau_dstage_t stage5_q, stage_d;
  logic [cau_pkg::HiW-1:0] hre, him;

  always_comb begin
    hre            = mre4_q[cau_pkg::NumShW-1:cau_pkg::OpW];
    him            = mim4_q[cau_pkg::NumShW-1:cau_pkg::OpW];
    stage_d.side   = side4_q;
    stage_d.dz     = dz4_q;
    stage_d.den    = den4_q;
    stage_d.re.neg = nre_neg4_q;
    stage_d.re.ovf = (cau_pkg::ProdW'(hre) >= den4_q);
    stage_d.re.rem = cau_pkg::ProdW'(hre);
    stage_d.re.mq  = mre4_q[cau_pkg::OpW-1:0];
    stage_d.im.neg = nim_neg4_q;
    stage_d.im.ovf = (cau_pkg::ProdW'(him) >= den4_q);
    stage_d.im.rem = cau_pkg::ProdW'(him);
    stage_d.im.mq  = mim4_q[cau_pkg::OpW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      stage5_q <= stage_d;
    end
  end

  assign stage_o = stage5_q;

endmodule

`default_nettype wire

/* hw/rtl/cau_div_step.sv */
// one restoring-division step for both quotient lanes, one register stage
// depends on cau_pkg
`default_nettype none

module cau_div_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  cau_pkg::cau_dstage_t stage_i,
  output logic                 vld_o,
  output cau_pkg::cau_dstage_t stage_o
);

  function automatic cau_pkg::cau_lane_t div_bit(cau_pkg::cau_lane_t l,
                                                 logic [cau_pkg::ProdW-1:0] den);
    logic [cau_pkg::ProdW:0] r2;
    logic [cau_pkg::ProdW:0] diff;
    cau_pkg::cau_lane_t      o;
    r2   = {l.rem, l.mq[cau_pkg::OpW-1]};
    diff = r2 - {1'b0, den};
    o    = l;
    if (r2 >= {1'b0, den}) begin
      o.rem = diff[cau_pkg::ProdW-1:0];
      o.mq  = {l.mq[cau_pkg::OpW-2:0], 1'b1};
    end else begin
      o.rem = r2[cau_pkg::ProdW-1:0];
      o.mq  = {l.mq[cau_pkg::OpW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic                 vld_q;
  cau_pkg::cau_dstage_t stage_q, stage_d;

  always_comb begin
    stage_d    = stage_i;
    stage_d.re = div_bit(stage_i.re, stage_i.den);
    stage_d.im = div_bit(stage_i.im, stage_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign vld_o   = vld_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

/* hw/rtl/cau_back.sv */
// output stage: quotient sign and saturation, status merge, result register
// depends on cau_pkg
`default_nettype none

module cau_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  cau_pkg::cau_dstage_t           stage_i,
  output logic                           vld_o,
  output logic [cau_pkg::OpW-1:0]        res_re_o,
  output logic [cau_pkg::OpW-1:0]        res_im_o,
  output logic [1:0]                     status_o
);

  localparam logic [cau_pkg::OpW-1:0] MaxPos = {1'b0, {(cau_pkg::OpW-1){1'b1}}};
  localparam logic [cau_pkg::OpW-1:0] MinNeg = {1'b1, {(cau_pkg::OpW-1){1'b0}}};

  logic                    vld_q;
  logic [cau_pkg::OpW-1:0] rre_q, rim_q, rre_d, rim_d;
  logic [1:0]              st_q, st_d;
  logic                    sre, sim;

  always_comb begin
    sre = stage_i.re.ovf || (stage_i.re.mq > (stage_i.re.neg ? MinNeg : MaxPos));
    sim = stage_i.im.ovf || (stage_i.im.mq > (stage_i.im.neg ? MinNeg : MaxPos));
    if (!stage_i.side.is_div) begin
      rre_d = stage_i.side.rr;
      rim_d = stage_i.side.ri;
      st_d  = stage_i.side.st;
    end else if (stage_i.dz) begin
      rre_d = '0;
      rim_d = '0;
      st_d  = cau_pkg::StDivZero;
    end else begin
      if (sre) begin
        rre_d = stage_i.re.neg ? MinNeg : MaxPos;
      end else begin
        rre_d = stage_i.re.neg ? -stage_i.re.mq : stage_i.re.mq;
      end
      if (sim) begin
        rim_d = stage_i.im.neg ? MinNeg : MaxPos;
      end else begin
        rim_d = stage_i.im.neg ? -stage_i.im.mq : stage_i.im.mq;
      end
      st_d = (sre || sim) ? cau_pkg::StSat : cau_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rre_q <= rre_d;
      rim_q <= rim_d;
      st_q  <= st_d;
    end
  end

  assign vld_o    = vld_q;
  assign res_re_o = rre_q;
  assign res_im_o = rim_q;
  assign status_o = st_q;

endmodule

`default_nettype wire
